@@ rtl/mlfd_pkg.sv @@
`timescale 1ns / 1ps
// Shared types, constants and the segment decoder of the meter LCD frame decoder.
package mlfd_pkg;

	localparam int FRAME_BYTES = 24;        // 17 .. 64
	localparam int STORE_DEPTH = 17;        // frame bytes 0..16 are kept
	localparam int CNT_W       = 6;
	localparam int ADDR_W      = 5;
	localparam int DIGIT_W     = 4;
	localparam int POS_W       = 3;

	localparam int MAIN_FIRST  = 3;
	localparam int MAIN_DIGITS = 6;
	localparam int SUB_FIRST   = 10;
	localparam int SUB_DIGITS  = 4;
	localparam int NUM_DIGITS  = MAIN_DIGITS + SUB_DIGITS;

	localparam int MANT_W      = 20;
	localparam int SUB_MANT_W  = 14;

	localparam logic [7:0] MODEL_ID_RESET = 8'd134;

	// segment classes: 0..9 are decimal digits
	localparam logic [3:0] CLS_L     = 4'd10;
	localparam logic [3:0] CLS_MINUS = 4'd11;
	localparam logic [3:0] CLS_BLANK = 4'd12;
	localparam logic [3:0] CLS_OTHER = 4'd13;
	localparam logic [3:0] CLS_MAX_DIGIT = 4'd9;

	// display status codes
	localparam logic [1:0] STAT_NUMBER   = 2'd0;
	localparam logic [1:0] STAT_OVERLOAD = 2'd1;
	localparam logic [1:0] STAT_NONE     = 2'd2;

	typedef logic [STORE_DEPTH-1:0][7:0] frame_t;

	typedef struct packed {
		logic             en;
		logic             first;
		logic [POS_W-1:0] pos;
	} step_t;

	typedef struct packed {
		logic [1:0]        status;
		logic              neg;
		logic [MANT_W-1:0] mant;
		logic [POS_W-1:0]  decs;
	} disp_res_t;

	// segment pattern sits in bits 7:1 of a display byte
	function automatic logic [3:0] seg_class(input logic [7:0] b);
		logic [6:0] code;
		logic [3:0] cls;
		code = b[7:1];
		unique case (code)
			7'h00:   cls = CLS_BLANK;
			7'h5F:   cls = 4'd0;
			7'h50:   cls = 4'd1;
			7'h6D:   cls = 4'd2;
			7'h7C:   cls = 4'd3;
			7'h72:   cls = 4'd4;
			7'h3E:   cls = 4'd5;
			7'h3F:   cls = 4'd6;
			7'h54:   cls = 4'd7;
			7'h7F:   cls = 4'd8;
			7'h7E:   cls = 4'd9;
			7'h0B:   cls = CLS_L;
			7'h01:   cls = CLS_MINUS;
			default: cls = CLS_OTHER;
		endcase
		return cls;
	endfunction

endpackage

@@ rtl/mlfd_frame_collect.sv @@
`timescale 1ns / 1ps
// Frame collector: byte counter, discard state and the frame byte store.
module mlfd_frame_collect (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        accept,
	input  logic [7:0]                  data_byte,
	input  logic                        chunk_end,
	input  logic                        restart,
	input  logic [mlfd_pkg::ADDR_W-1:0] rd_addr,
	output logic [7:0]                  rd_data,
	output mlfd_pkg::frame_t            frame,
	output logic                        frame_done
);

	logic [mlfd_pkg::CNT_W-1:0] count_q;
	logic                       discard_q;
	logic [mlfd_pkg::CNT_W:0]   cnt_inc;
	logic                       done_hit;
	logic                       take;
	logic [7:0]                 store_q [mlfd_pkg::STORE_DEPTH];

	assign cnt_inc    = {1'b0, count_q} + (mlfd_pkg::CNT_W+1)'(1);
	assign done_hit   = cnt_inc >= (mlfd_pkg::CNT_W+1)'(mlfd_pkg::FRAME_BYTES);
	assign take       = accept && !restart && !discard_q;
	assign frame_done = take && done_hit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= '0;
			discard_q <= 1'b0;
		end else if (accept) begin
			if (restart) begin
				count_q   <= '0;
				discard_q <= 1'b0;
			end else if (discard_q) begin
				if (chunk_end) begin
					discard_q <= 1'b0;
				end
			end else if (done_hit) begin
				count_q   <= '0;
				discard_q <= !chunk_end;
			end else begin
				count_q <= cnt_inc[mlfd_pkg::CNT_W-1:0];
			end
		end
	end

	// bytes past the last decoded offset are counted only
	always_ff @(posedge clk) begin
		if (take && count_q < mlfd_pkg::CNT_W'(mlfd_pkg::STORE_DEPTH)) begin
			store_q[count_q[mlfd_pkg::ADDR_W-1:0]] <= data_byte;
		end
	end

	assign rd_data = store_q[rd_addr];

	always_comb begin
		for (int k = 0; k < mlfd_pkg::STORE_DEPTH; k++) begin
			frame[k] = store_q[k];
		end
	end

endmodule

@@ rtl/mlfd_digit_acc.sv @@
`timescale 1ns / 1ps
// Shared digit unit: one display digit per step, multiply-by-ten accumulate.
module mlfd_digit_acc (
	input  logic                clk,
	input  mlfd_pkg::step_t     step,
	input  logic [7:0]          digit_byte,
	output mlfd_pkg::disp_res_t res
);

	logic [mlfd_pkg::MANT_W-1:0] m_q,  m_b, m_d;
	logic [mlfd_pkg::POS_W-1:0]  cnt_q, cnt_b, cnt_d;
	logic [mlfd_pkg::POS_W-1:0]  dp_q, dp_b, dp_d;
	logic                        ol_q, ol_b, ol_d;
	logic                        lead_q, lead_b, lead_d;
	logic                        neg_q, neg_b, neg_d;
	logic [3:0]                  cls;
	logic                        is_num;

	assign cls = mlfd_pkg::seg_class(digit_byte);

	// first digit of a display starts from a clean accumulator
	always_comb begin
		m_b    = step.first ? '0   : m_q;
		cnt_b  = step.first ? '0   : cnt_q;
		dp_b   = step.first ? '0   : dp_q;
		ol_b   = step.first ? 1'b0 : ol_q;
		lead_b = step.first ? 1'b1 : lead_q;
		neg_b  = step.first ? 1'b0 : neg_q;
	end

	always_comb begin
		m_d    = m_b;
		cnt_d  = cnt_b;
		dp_d   = dp_b;
		ol_d   = ol_b || (cls == mlfd_pkg::CLS_L);
		lead_d = lead_b;
		neg_d  = neg_b;
		// point bit of this digit places the point before it
		if (dp_b == '0 && step.pos != '0 && digit_byte[0]) begin
			dp_d = step.pos;
		end
		if (lead_b && cls == mlfd_pkg::CLS_MINUS) begin
			neg_d = 1'b1;
		end else if (!(lead_b && cls == mlfd_pkg::CLS_BLANK)) begin
			lead_d = 1'b0;
			if (cls <= mlfd_pkg::CLS_MAX_DIGIT) begin
				m_d   = {m_b[mlfd_pkg::MANT_W-4:0], 3'b000}
					+ {m_b[mlfd_pkg::MANT_W-2:0], 1'b0}
					+ mlfd_pkg::MANT_W'(cls);
				cnt_d = cnt_b + mlfd_pkg::POS_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (step.en) begin
			m_q    <= m_d;
			cnt_q  <= cnt_d;
			dp_q   <= dp_d;
			ol_q   <= ol_d;
			lead_q <= lead_d;
			neg_q  <= neg_d;
		end
	end

	assign is_num = !ol_q && cnt_q != '0;

	always_comb begin
		res.neg = neg_q;
		if (ol_q) begin
			res.status = mlfd_pkg::STAT_OVERLOAD;
		end else if (cnt_q == '0) begin
			res.status = mlfd_pkg::STAT_NONE;
		end else begin
			res.status = mlfd_pkg::STAT_NUMBER;
		end
		res.mant = is_num ? m_q : '0;
		res.decs = (is_num && dp_q != '0 && dp_q < cnt_q) ? cnt_q - dp_q : '0;
	end

endmodule

@@ rtl/meter_lcd_frame_decoder.sv @@
`timescale 1ns / 1ps
// Top level: collects LCD frames and decodes each one into a meter reading.
//
//  channel | handshake             | payload
//  --------+-----------------------+-----------------------------------------
//  in      | in_valid / in_ready   | data_byte, chunk_end, restart
//  out     | out_valid / out_ready | valid_res, mode_flags, main_*, sub_*
//  cfg     | cfg_valid / cfg_ready | cfg_data (model id)
//
// A byte that does not complete a frame is taken while in_ready stays high.
// A completing byte starts the decode: the shared digit unit walks the ten
// display digits, one per cycle, then the output register is loaded once
// the output slot is free, so in_ready stays low until the reading is loaded.
// The digit walk does one multiply-by-ten accumulate per digit.
// Reset clears the byte count, discard state and the output valid flag;
// model id returns to 134. cfg_ready is always high.
module meter_lcd_frame_decoder (
	input  logic        clk,
	input  logic        arst_n,
	// input bytes
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  data_byte,
	input  logic        chunk_end,
	input  logic        restart,
	// decoded readings
	output logic        out_valid,
	input  logic        out_ready,
	output logic        valid_res,
	output logic [5:0]  mode_flags,
	output logic [7:0]  main_unit,
	output logic [1:0]  main_status,
	output logic        main_negative,
	output logic [19:0] main_mantissa,
	output logic [2:0]  main_decimals,
	output logic [5:0]  sub_unit,
	output logic [1:0]  sub_status,
	output logic        sub_negative,
	output logic [13:0] sub_mantissa,
	output logic [1:0]  sub_decimals,
	// configuration
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [7:0]  cfg_data
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_RUN  = 2'd1;
	localparam logic [1:0] ST_DONE = 2'd2;

	logic [1:0]                    state_q;
	logic [mlfd_pkg::DIGIT_W-1:0]  di_q;
	logic [7:0]                    model_id_q;
	logic                          in_accept;
	logic                          frame_done;
	logic [mlfd_pkg::ADDR_W-1:0]   rd_addr;
	logic [7:0]                    rd_data;
	mlfd_pkg::frame_t              frame;
	mlfd_pkg::step_t               step;
	mlfd_pkg::disp_res_t           disp_res;
	mlfd_pkg::disp_res_t           main_hold_q;
	logic                          in_main;
	logic                          out_free;
	logic                          load_out;

	// unit decode
	logic [1:0] m_cpl, s_cpl;
	logic [2:0] m_pre, m_base, s_pre;
	logic [1:0] s_base;

	// output register
	logic                 out_valid_q;
	logic                 valid_res_q;
	logic [5:0]           mode_flags_q;
	logic [7:0]           main_unit_q;
	mlfd_pkg::disp_res_t  main_res_q;
	logic [5:0]           sub_unit_q;
	mlfd_pkg::disp_res_t  sub_res_q;

	assign cfg_ready = 1'b1;
	assign in_ready  = (state_q == ST_IDLE);
	assign in_accept = in_valid && in_ready;
	assign out_free  = !out_valid_q || out_ready;
	assign load_out  = (state_q == ST_DONE) && out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			model_id_q <= mlfd_pkg::MODEL_ID_RESET;
		end else if (cfg_valid) begin
			model_id_q <= cfg_data;
		end
	end

	mlfd_frame_collect u_collect (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (in_accept),
		.data_byte  (data_byte),
		.chunk_end  (chunk_end),
		.restart    (restart),
		.rd_addr    (rd_addr),
		.rd_data    (rd_data),
		.frame      (frame),
		.frame_done (frame_done)
	);

	// digit sequencer: main digits at bytes 3..8, secondary at 10..13
	assign in_main = di_q < mlfd_pkg::DIGIT_W'(mlfd_pkg::MAIN_DIGITS);

	always_comb begin
		if (in_main) begin
			rd_addr  = mlfd_pkg::ADDR_W'(mlfd_pkg::MAIN_FIRST) + mlfd_pkg::ADDR_W'(di_q);
			step.pos = mlfd_pkg::POS_W'(di_q);
		end else begin
			rd_addr  = mlfd_pkg::ADDR_W'(mlfd_pkg::SUB_FIRST) + mlfd_pkg::ADDR_W'(di_q)
				- mlfd_pkg::ADDR_W'(mlfd_pkg::MAIN_DIGITS);
			step.pos = mlfd_pkg::POS_W'(di_q - mlfd_pkg::DIGIT_W'(mlfd_pkg::MAIN_DIGITS));
		end
		step.en    = (state_q == ST_RUN);
		step.first = (di_q == '0) || (di_q == mlfd_pkg::DIGIT_W'(mlfd_pkg::MAIN_DIGITS));
	end

	mlfd_digit_acc u_digit (
		.clk        (clk),
		.step       (step),
		.digit_byte (rd_data),
		.res        (disp_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			di_q    <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (frame_done) begin
						state_q <= ST_RUN;
						di_q    <= '0;
					end
				end
				ST_RUN: begin
					if (di_q == mlfd_pkg::DIGIT_W'(mlfd_pkg::NUM_DIGITS - 1)) begin
						state_q <= ST_DONE;
					end
					di_q <= di_q + mlfd_pkg::DIGIT_W'(1);
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// the unit still holds the main display when the first secondary digit steps
	always_ff @(posedge clk) begin
		if (step.en && di_q == mlfd_pkg::DIGIT_W'(mlfd_pkg::MAIN_DIGITS)) begin
			main_hold_q <= disp_res;
		end
	end

	// priority-encoded units, straight from fixed frame bytes
	always_comb begin
		m_cpl = frame[2][2] ? 2'd1 : (frame[2][1] ? 2'd2 : 2'd0);
		if      (frame[15][5]) m_pre = 3'd1;
		else if (frame[15][6]) m_pre = 3'd2;
		else if (frame[15][2]) m_pre = 3'd3;
		else if (frame[15][3]) m_pre = 3'd4;
		else if (frame[14][6]) m_pre = 3'd5;
		else                   m_pre = 3'd0;
		if      (frame[8][0])  m_base = 3'd1;
		else if (frame[14][7]) m_base = 3'd2;
		else if (frame[15][4]) m_base = 3'd3;
		else if (frame[15][0]) m_base = 3'd4;
		else if (frame[14][5]) m_base = 3'd5;
		else if (frame[14][4]) m_base = 3'd6;
		else if (frame[15][1]) m_base = 3'd7;
		else                   m_base = 3'd0;

		s_cpl = frame[9][5] ? 2'd1 : (frame[9][4] ? 2'd2 : 2'd0);
		if      (frame[14][0]) s_pre = 3'd1;
		else if (frame[14][1]) s_pre = 3'd2;
		else if (frame[9][1])  s_pre = 3'd3;
		else if (frame[9][0])  s_pre = 3'd4;
		else                   s_pre = 3'd0;
		if      (frame[14][3]) s_base = 2'd1;
		else if (frame[9][2])  s_base = 2'd2;
		else if (frame[14][2]) s_base = 2'd3;
		else                   s_base = 2'd0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			valid_res_q  <= (frame[16] == model_id_q);
			mode_flags_q <= {frame[1][7:3], frame[1][0]};
			main_unit_q  <= 8'(m_cpl) * 8'd48 + {2'b00, m_pre, m_base};
			main_res_q   <= main_hold_q;
			sub_unit_q   <= 6'(s_cpl) * 6'd20 + {1'b0, s_pre, s_base};
			sub_res_q    <= disp_res;
		end
	end

	assign out_valid     = out_valid_q;
	assign valid_res     = valid_res_q;
	assign mode_flags    = mode_flags_q;
	assign main_unit     = main_unit_q;
	assign main_status   = main_res_q.status;
	assign main_negative = main_res_q.neg;
	assign main_mantissa = main_res_q.mant;
	assign main_decimals = main_res_q.decs;
	assign sub_unit      = sub_unit_q;
	assign sub_status    = sub_res_q.status;
	assign sub_negative  = sub_res_q.neg;
	assign sub_mantissa  = sub_res_q.mant[mlfd_pkg::SUB_MANT_W-1:0];
	assign sub_decimals  = sub_res_q.decs[1:0];

	// a completed frame closes the input until its reading is loaded
	a_busy_after_frame: assert property (@(posedge clk) disable iff (!arst_n)
		frame_done |=> !in_ready)
		else $error("input open during frame decode");

	// a reading that is not a number carries no mantissa or decimals
	a_main_not_number: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && main_status != mlfd_pkg::STAT_NUMBER)
		|-> (main_mantissa == '0 && main_decimals == '0))
		else $error("main display not a number but mantissa set");

	// finished decode with a free output slot yields a reading
	a_done_loads: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE && out_free) |=> (out_valid && in_ready))
		else $error("finished decode did not load output");

endmodule
